// ----- design/hashed_key_value_store_macros.svh -----
// ----------------------------------------------------------------------------
// hashed_key_value_store_macros: assertion helpers
// Same-cycle and next-cycle implication checks, disabled while the reset is low.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_VALUE_STORE_MACROS_SVH
`define HASHED_KEY_VALUE_STORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HKVS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HKVS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/hkvs_pkg.sv -----
// ----------------------------------------------------------------------------
// hkvs_pkg: shared types and constants
// Operation codes, field widths and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package hkvs_pkg;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 20;
    localparam int READ_W  = 21;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // -1 in the result field
    localparam logic signed [READ_W-1:0] READ_MISS = '1;

    typedef struct packed {
        logic capture;
        logic hash_q;
        logic hash_r;
        logic rd_req;
        logic update;
        logic clear_wr;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } stat_t;

endpackage

// ----- design/hkvs_ram.sv -----
// ----------------------------------------------------------------------------
// hkvs_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hkvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/hkvs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkvs_ctrl: request sequencer
// Runs the clearing pass after reset, then takes one request at a time
// through bucket reduction, row read and row update.
// ----------------------------------------------------------------------------
module hkvs_ctrl #(
    parameter int NUM_BUCKETS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  hkvs_pkg::stat_t stat,
    output hkvs_pkg::cmd_t  cmd
);
    import hkvs_pkg::*;

    localparam int BW      = $clog2(NUM_BUCKETS);
    localparam bit IS_POW2 = ((1 << BW) == NUM_BUCKETS);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH_Q = 3'd2;
    localparam logic [2:0] ST_HASH_R = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_UPDATE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (IS_POW2) begin
                        // bucket is the low key bits, read straight away
                        cmd.rd_req = 1'b1;
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_HASH_Q;
                    end
                end
            end
            ST_HASH_Q: begin
                cmd.hash_q = 1'b1;
                state_next = ST_HASH_R;
            end
            ST_HASH_R: begin
                cmd.hash_r = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                cmd.rd_req = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                // hold until the output register can take the beat
                if (stat.out_free) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/hkvs_dpath.sv -----
// ----------------------------------------------------------------------------
// hkvs_dpath: request datapath
// Request registers, bucket reduction, bucket row ram, way compare and
// row update, clearing counter and output register.
// ----------------------------------------------------------------------------
module hkvs_dpath #(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS        = 4,
    parameter int KEY_BITS    = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hkvs_pkg::cmd_t                        cmd,
    output hkvs_pkg::stat_t                       stat,
    input  logic [hkvs_pkg::OP_W-1:0]             s_operation,
    input  logic [KEY_BITS-1:0]                   s_key,
    input  logic [hkvs_pkg::VALUE_W-1:0]          s_value,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic                                  m_status,
    output logic signed [hkvs_pkg::READ_W-1:0]    m_read_value
);
    import hkvs_pkg::*;

    localparam int BW      = $clog2(NUM_BUCKETS);
    localparam bit IS_POW2 = ((1 << BW) == NUM_BUCKETS);
    localparam int WAY_W   = 1 + KEY_BITS + VALUE_W;
    localparam int ROW_W   = WAYS * WAY_W;
    localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

    logic [OP_W-1:0]    op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [BW-1:0]      clr_addr_reg;
    logic [BW-1:0]      bucket_rd;
    logic [BW-1:0]      bucket_cur;

    logic               ram_we;
    logic [BW-1:0]      ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   row_next;

    logic [WAYS-1:0]    way_valid;
    logic [WAYS-1:0]    hit_vec;
    logic [WAYS-1:0]    hit_oh;
    logic [WAYS-1:0]    free_oh;
    logic [KEY_BITS-1:0] way_key [WAYS];
    logic [VALUE_W-1:0] way_value [WAYS];
    logic [VALUE_W-1:0] hit_value;

    logic               m_valid_reg;
    logic               status_reg;
    logic               status_next;
    logic signed [READ_W-1:0] read_value_reg;
    logic signed [READ_W-1:0] read_value_next;

    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            op_reg    <= s_operation;
            key_reg   <= s_key;
            value_reg <= s_value;
        end
    end

    // bucket = key mod NUM_BUCKETS
    if (IS_POW2) begin : g_mask
        logic [KEY_BITS+BW-1:0] s_key_pad;
        logic [KEY_BITS+BW-1:0] key_pad;

        assign s_key_pad  = (KEY_BITS + BW)'(s_key);
        assign key_pad    = (KEY_BITS + BW)'(key_reg);
        assign bucket_rd  = s_key_pad[BW-1:0];
        assign bucket_cur = key_pad[BW-1:0];
    end else begin : g_recip
        localparam int SHIFT  = KEY_BITS + BW;
        localparam int PROD_W = SHIFT + KEY_BITS;
        localparam int REM_W  = KEY_BITS + BW + 1;
        localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(NUM_BUCKETS);
        localparam logic [KEY_BITS:0] RECIP = RECIP_FULL[KEY_BITS:0];
        localparam logic [BW:0] BUCKETS_C = (BW + 1)'(NUM_BUCKETS);

        logic [PROD_W-1:0]   quot_prod;
        logic [KEY_BITS-1:0] quot_reg;
        logic [REM_W-1:0]    qn_prod;
        logic [REM_W-1:0]    rem_full;
        logic [BW:0]         rem;
        logic [BW-1:0]       bucket_reg;
        logic [BW-1:0]       bucket_next;

        // floor reciprocal: quotient estimate is exact or one short
        assign quot_prod = PROD_W'(key_reg) * PROD_W'(RECIP);
        assign qn_prod   = REM_W'(quot_reg) * REM_W'(BUCKETS_C);
        assign rem_full  = REM_W'(key_reg) - qn_prod;
        assign rem       = rem_full[BW:0];

        always_comb begin
            if (rem >= BUCKETS_C) begin
                bucket_next = BW'(rem - BUCKETS_C);
            end else begin
                bucket_next = rem[BW-1:0];
            end
        end

        always_ff @(posedge clk) begin
            if (cmd.hash_q) begin
                quot_reg <= quot_prod[SHIFT +: KEY_BITS];
            end
            if (cmd.hash_r) begin
                bucket_reg <= bucket_next;
            end
        end

        assign bucket_rd  = bucket_reg;
        assign bucket_cur = bucket_reg;
    end

    assign ram_we    = cmd.clear_wr | cmd.update;
    assign ram_waddr = cmd.clear_wr ? clr_addr_reg : bucket_cur;
    assign ram_wdata = cmd.clear_wr ? '0 : row_next;

    hkvs_ram #(
        .WIDTH(ROW_W),
        .DEPTH(NUM_BUCKETS)
    ) u_row_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (cmd.rd_req),
        .rd_addr(bucket_rd),
        .rd_data(ram_rdata)
    );

    // way layout: {valid, key, value}
    for (genvar w = 0; w < WAYS; w++) begin : g_way
        assign way_valid[w] = ram_rdata[w*WAY_W + WAY_W - 1];
        assign way_key[w]   = ram_rdata[w*WAY_W + VALUE_W +: KEY_BITS];
        assign way_value[w] = ram_rdata[w*WAY_W +: VALUE_W];
        assign hit_vec[w]   = way_valid[w] && (way_key[w] == key_reg);
    end

    // lowest matching way and lowest free way, one-hot
    assign hit_oh  = hit_vec & (~hit_vec + WAYS'(1));
    assign free_oh = ~way_valid & (way_valid + WAYS'(1));

    always_comb begin
        row_next        = ram_rdata;
        status_next     = 1'b0;
        read_value_next = READ_MISS;
        hit_value       = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
                hit_value = hit_value | way_value[w];
            end
        end
        case (op_reg)
            OP_INSERT: begin
                if (|hit_vec) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_oh[w]) begin
                            row_next[w*WAY_W +: VALUE_W] = value_reg;
                        end
                    end
                end else if (|free_oh) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_oh[w]) begin
                            row_next[w*WAY_W +: WAY_W] = {1'b1, key_reg, value_reg};
                        end
                    end
                end else begin
                    status_next = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (|hit_vec) begin
                    read_value_next = signed'({1'b0, hit_value});
                end
            end
            OP_DELETE: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_oh[w]) begin
                        row_next[w*WAY_W + WAY_W - 1] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_wr) begin
            clr_addr_reg <= clr_addr_reg + BW'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.update) begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
        end
    end

    assign stat.clear_done = (clr_addr_reg == LAST_BUCKET);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_read_value = read_value_reg;

endmodule

// ----- design/hashed_key_value_store.sv -----
// ----------------------------------------------------------------------------
// hashed_key_value_store: bucketed key/value map with WAYS entries per bucket
// power-of-two NUM_BUCKETS: bucket is the low key bits, row read in the accept cycle
// other NUM_BUCKETS: reciprocal bucket reduction plus a separate row read
// both: one request at a time, and the row update waits until the output slot is free
// after reset s_ready stays low while the rows are cleared one per cycle
// ----------------------------------------------------------------------------
`include "hashed_key_value_store_macros.svh"

module hashed_key_value_store #(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS        = 4,
    parameter int KEY_BITS    = 20
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [hkvs_pkg::OP_W-1:0]          s_operation,
    input  logic [KEY_BITS-1:0]                s_key,
    input  logic [hkvs_pkg::VALUE_W-1:0]       s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_status,
    output logic signed [hkvs_pkg::READ_W-1:0] m_read_value
);
    import hkvs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hkvs_ctrl #(
        .NUM_BUCKETS(NUM_BUCKETS)
    ) u_ctrl (
        .clk    (aclk),
        .rst_n  (aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    hkvs_dpath #(
        .NUM_BUCKETS(NUM_BUCKETS),
        .WAYS       (WAYS),
        .KEY_BITS   (KEY_BITS)
    ) u_dpath (
        .clk         (aclk),
        .rst_n       (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_value     (s_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_status    (m_status),
        .m_read_value(m_read_value)
    );

    `HKVS_ASSERT_NOW(a_update_out_free, aclk, aresetn, cmd.update, stat.out_free, "update while output busy")
    `HKVS_ASSERT_NOW(a_clear_not_ready, aclk, aresetn, cmd.clear_wr, !s_ready, "ready during clearing pass")
    `HKVS_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `HKVS_ASSERT_NOW(a_full_reads_miss, aclk, aresetn, m_valid && m_status, m_read_value == READ_MISS, "full status with read data")

endmodule
